// File: sv/mhps_pkg.sv
// Shared types and codes for the min-heap priority store.
package mhps_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [STATUS_W-1:0]       status_t;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // result status codes
  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

endpackage

// File: sv/mhps_cell.sv
// One heap level: key store for that level plus its slot in the read-data chain.
module mhps_cell #(
  parameter int LEVEL     = 0,
  parameter int DEPTH     = 1,
  parameter int KEY_WIDTH = 32,
  parameter int LW        = 4,
  parameter int OW        = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [LW-1:0]        wr_lvl,
  input  logic [OW-1:0]        wr_off,
  input  logic [KEY_WIDTH-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [LW-1:0]        rd_lvl,
  input  logic [OW-1:0]        rd_off_a,
  input  logic [OW-1:0]        rd_off_b,
  input  logic [KEY_WIDTH-1:0] chain_in_a,
  input  logic [KEY_WIDTH-1:0] chain_in_b,
  output logic [KEY_WIDTH-1:0] chain_out_a,
  output logic [KEY_WIDTH-1:0] chain_out_b
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_a;
  logic [KEY_WIDTH-1:0] rd_b;
  logic                 sel;
  logic                 wr_hit;
  logic                 rd_hit;

  assign wr_hit = wr_en && (wr_lvl == LW'(LEVEL));
  assign rd_hit = rd_en && (rd_lvl == LW'(LEVEL));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_off[AW-1:0]] <= wr_data;
    end
    if (rd_hit) begin
      rd_a <= mem[rd_off_a[AW-1:0]];
      rd_b <= mem[rd_off_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else begin
      sel <= rd_hit;
    end
  end

  // the level that was read drives the chain, the others pass it on upwards
  assign chain_out_a = sel ? rd_a : chain_in_a;
  assign chain_out_b = sel ? rd_b : chain_in_b;

endmodule

// File: sv/mhps_ctrl.sv
// Sequencer for insert (sift-up), search, swap and heap rebuild (sift-down).
module mhps_ctrl #(
  parameter int CAPACITY  = 128,
  parameter int KEY_WIDTH = 32,
  parameter int LW        = 4,
  parameter int OW        = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 action,
  input  mhps_pkg::value_t     value,
  output logic                 result_valid,
  input  logic                 result_ready,
  output mhps_pkg::status_t    status,
  output mhps_pkg::count_t     count,
  output logic                 has_min,
  output mhps_pkg::value_t     min_value,
  output logic                 wr_en,
  output logic [LW-1:0]        wr_lvl,
  output logic [OW-1:0]        wr_off,
  output logic [KEY_WIDTH-1:0] wr_data,
  output logic                 rd_en,
  output logic [LW-1:0]        rd_lvl,
  output logic [OW-1:0]        rd_off_a,
  output logic [OW-1:0]        rd_off_b,
  input  logic [KEY_WIDTH-1:0] rd_data_a,
  input  logic [KEY_WIDTH-1:0] rd_data_b
);

  import mhps_pkg::*;

  localparam int IXW = OW + 3;
  localparam int SW  = 4;

  localparam logic [SW-1:0] S_IDLE     = 4'd0;
  localparam logic [SW-1:0] S_UP_RD    = 4'd1;
  localparam logic [SW-1:0] S_UP_CMP   = 4'd2;
  localparam logic [SW-1:0] S_SR_RD    = 4'd3;
  localparam logic [SW-1:0] S_SR_CMP   = 4'd4;
  localparam logic [SW-1:0] S_DEL_RD   = 4'd5;
  localparam logic [SW-1:0] S_DEL_WR   = 4'd6;
  localparam logic [SW-1:0] S_SD_START = 4'd7;
  localparam logic [SW-1:0] S_SD_LOAD  = 4'd8;
  localparam logic [SW-1:0] S_SD_RD    = 4'd9;
  localparam logic [SW-1:0] S_SD_CMP   = 4'd10;
  localparam logic [SW-1:0] S_DONE     = 4'd11;

  localparam logic [KEY_WIDTH-1:0] KeyTop = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // heap position as (level, offset within level)
  typedef struct packed {
    logic [LW-1:0] l;
    logic [OW-1:0] o;
  } pos_t;

  function automatic logic [OW:0] lvl_size(logic [LW-1:0] l);
    return (OW+1)'(1) << l;
  endfunction

  function automatic pos_t pos_inc(pos_t p);
    pos_t r;
    r = p;
    if ({1'b0, p.o} == lvl_size(p.l) - 1'b1) begin
      r.l = p.l + 1'b1;
      r.o = '0;
    end else begin
      r.o = p.o + 1'b1;
    end
    return r;
  endfunction

  function automatic pos_t pos_dec(pos_t p);
    pos_t r;
    r = p;
    if (p.o == '0) begin
      r.l = p.l - 1'b1;
      r.o = OW'(lvl_size(p.l - 1'b1) - 1'b1);
    end else begin
      r.o = p.o - 1'b1;
    end
    return r;
  endfunction

  function automatic pos_t pos_parent(pos_t p);
    pos_t r;
    r.l = p.l - 1'b1;
    r.o = p.o >> 1;
    return r;
  endfunction

  function automatic logic [IXW-1:0] pos_flat(pos_t p);
    return IXW'(lvl_size(p.l)) - IXW'(1) + IXW'(p.o);
  endfunction

  logic [SW-1:0]        state;
  logic [OW-1:0]        cnt;
  logic [OW-1:0]        si;
  pos_t                 tail;
  pos_t                 pos;
  pos_t                 node;
  logic [KEY_WIDTH-1:0] key;
  logic [KEY_WIDTH-1:0] val;
  logic [KEY_WIDTH-1:0] root;
  status_t              status_r;

  logic signed [KEY_WIDTH-1:0] key_sx;
  logic [KEY_WIDTH-1:0]        key_in;
  logic signed [KEY_WIDTH-1:0] root_key;

  pos_t                 par_p;
  pos_t                 chl_p;
  pos_t                 chr_p;
  logic [IXW-1:0]       cl_ix;
  logic                 has_l;
  logic                 has_r;
  logic                 take_l;
  logic                 take_r;
  logic                 moved;
  logic [KEY_WIDTH-1:0] lmin;
  pos_t                 wr_p;
  pos_t                 rd_p;

  // offset-binary keys: plain unsigned compare gives signed order
  assign key_sx   = KEY_WIDTH'(value);
  assign key_in   = key_sx ^ KeyTop;
  assign root_key = root ^ KeyTop;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    par_p   = pos_parent(pos);
    chl_p.l = pos.l + 1'b1;
    chl_p.o = pos.o << 1;
    chr_p.l = chl_p.l;
    chr_p.o = (pos.o << 1) | OW'(1);
    cl_ix   = (pos_flat(pos) << 1) + IXW'(1);
    has_l   = cl_ix < IXW'(cnt);
    has_r   = (cl_ix + IXW'(1)) < IXW'(cnt);
    take_l  = rd_data_a < val;
    lmin    = take_l ? rd_data_a : val;
    take_r  = has_r && (rd_data_b < lmin);
    moved   = take_l || take_r;

    wr_en    = 1'b0;
    wr_p     = pos;
    wr_data  = val;
    rd_en    = 1'b0;
    rd_p     = pos;
    rd_off_b = pos.o;
    case (state)
      S_UP_RD: begin
        if (pos.l == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en = 1'b1;
          rd_p  = par_p;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (val < rd_data_a) begin
          wr_data = rd_data_a;
        end
      end
      S_SR_RD: begin
        rd_en = 1'b1;
      end
      S_DEL_RD: begin
        rd_en = 1'b1;
        rd_p  = tail;
      end
      S_DEL_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_a;
      end
      S_SD_START: begin
        rd_en = 1'b1;
        rd_p  = node;
      end
      S_SD_RD: begin
        if (has_l) begin
          rd_en    = 1'b1;
          rd_p     = chl_p;
          rd_off_b = chr_p.o;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_SD_CMP: begin
        wr_en = 1'b1;
        if (moved) begin
          wr_data = take_r ? rd_data_b : rd_data_a;
        end
      end
      default: ;
    endcase
  end

  assign wr_lvl   = wr_p.l;
  assign wr_off   = wr_p.o;
  assign rd_lvl   = rd_p.l;
  assign rd_off_a = rd_p.o;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      tail         <= '0;
      result_valid <= 1'b0;
    end else begin
      // S_DONE reloads the result register itself
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      if (wr_en && (wr_p.l == '0)) begin
        root <= wr_data;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            key <= key_in;
            if (action == ACT_DELETE) begin
              if (cnt == '0) begin
                status_r <= ST_NOT_FOUND;
                state    <= S_DONE;
              end else begin
                status_r <= ST_DONE;
                pos      <= '0;
                si       <= '0;
                state    <= S_SR_RD;
              end
            end else if (cnt == OW'(CAPACITY)) begin
              status_r <= ST_FULL;
              state    <= S_DONE;
            end else begin
              status_r <= ST_DONE;
              pos      <= tail;
              val      <= key_in;
              tail     <= pos_inc(tail);
              cnt      <= cnt + 1'b1;
              state    <= S_UP_RD;
            end
          end
        end
        S_UP_RD: begin
          state <= (pos.l == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (val < rd_data_a) begin
            pos   <= par_p;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SR_RD: begin
          state <= S_SR_CMP;
        end
        S_SR_CMP: begin
          if (rd_data_a == key) begin
            tail  <= pos_dec(tail);
            cnt   <= cnt - 1'b1;
            state <= S_DEL_RD;
          end else if (si == cnt - 1'b1) begin
            status_r <= ST_NOT_FOUND;
            state    <= S_DONE;
          end else begin
            pos   <= pos_inc(pos);
            si    <= si + 1'b1;
            state <= S_SR_RD;
          end
        end
        S_DEL_RD: begin
          state <= S_DEL_WR;
        end
        S_DEL_WR: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            // first node to rebuild: parent of the slot just freed
            node  <= pos_parent(tail);
            state <= S_SD_START;
          end
        end
        S_SD_START: begin
          pos   <= node;
          state <= S_SD_LOAD;
        end
        S_SD_LOAD: begin
          val   <= rd_data_a;
          state <= S_SD_RD;
        end
        S_SD_RD: begin
          if (has_l) begin
            state <= S_SD_CMP;
          end else if (node.l == '0) begin
            state <= S_DONE;
          end else begin
            node  <= pos_dec(node);
            state <= S_SD_START;
          end
        end
        S_SD_CMP: begin
          if (moved) begin
            pos   <= take_r ? chr_p : chl_p;
            state <= S_SD_RD;
          end else if (node.l == '0) begin
            state <= S_DONE;
          end else begin
            node  <= pos_dec(node);
            state <= S_SD_START;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            status       <= status_r;
            count        <= COUNT_W'(cnt);
            has_min      <= (cnt != '0);
            min_value    <= (cnt != '0) ? VALUE_W'(root_key) : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/min_heap_priority_store.sv
// Binary min-heap priority store: top level joining the sequencer and the chain of level cells.
//
// Holds up to CAPACITY signed keys as a binary min-heap. An insert beat appends its key and
// sifts it up; a delete beat removes the first entry (in array order) equal to its key,
// moves the last entry into the hole and rebuilds the heap by sifting down every internal
// node from the bottom up. Each item beat yields one result beat carrying status (done,
// full, not found), the new count, and the current minimum (zero when empty). The heap is
// kept as a row of level cells, one per tree level, each owning the keys of its level in a
// small memory with registered read data; the read result of the addressed level travels up
// the chain of cells to the sequencer, and every sift step hands a key between neighbouring
// levels. Items are handled one at a time: an insert takes a read and a compare per level
// climbed; a delete takes a read and a compare per entry searched, then a read of the last
// entry and a write into the hole, and for each rebuilt node a load and then a read and a
// compare per sift step. Every step costs a read and a compare because each cell
// has one registered read per cycle. A finished result sits in an output register, so the
// next item beat is taken while the result waits. No clearing pass is needed after reset.
module min_heap_priority_store #(
  parameter int CAPACITY  = 128,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              action,
  input  mhps_pkg::value_t  value,
  output logic              result_valid,
  input  logic              result_ready,
  output mhps_pkg::status_t status,
  output mhps_pkg::count_t  count,
  output logic              has_min,
  output mhps_pkg::value_t  min_value
);

  import mhps_pkg::*;

  // levels needed to hold CAPACITY entries, and widths of a heap position
  localparam int LEVELS = $clog2(CAPACITY + 1);
  localparam int LW     = $clog2(LEVELS + 1);
  localparam int OW     = LEVELS;

  logic                 wr_en;
  logic [LW-1:0]        wr_lvl;
  logic [OW-1:0]        wr_off;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [LW-1:0]        rd_lvl;
  logic [OW-1:0]        rd_off_a;
  logic [OW-1:0]        rd_off_b;

  // read-data chain: index g is the output of cell g, the end beyond the last cell is zero
  logic [KEY_WIDTH-1:0] chain_a [LEVELS+1];
  logic [KEY_WIDTH-1:0] chain_b [LEVELS+1];

  assign chain_a[LEVELS] = '0;
  assign chain_b[LEVELS] = '0;

  mhps_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .LW        (LW),
    .OW        (OW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .value        (value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .count        (count),
    .has_min      (has_min),
    .min_value    (min_value),
    .wr_en        (wr_en),
    .wr_lvl       (wr_lvl),
    .wr_off       (wr_off),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_lvl       (rd_lvl),
    .rd_off_a     (rd_off_a),
    .rd_off_b     (rd_off_b),
    .rd_data_a    (chain_a[0]),
    .rd_data_b    (chain_b[0])
  );

  // level g holds heap entries 2^g-1 .. 2^(g+1)-2; the bottom level may be partial
  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    localparam int LSIZE = 1 << g;
    localparam int DEPTH = (LSIZE < CAPACITY - LSIZE + 1) ? LSIZE : CAPACITY - LSIZE + 1;

    mhps_cell #(
      .LEVEL     (g),
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH),
      .LW        (LW),
      .OW        (OW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .wr_en       (wr_en),
      .wr_lvl      (wr_lvl),
      .wr_off      (wr_off),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_lvl      (rd_lvl),
      .rd_off_a    (rd_off_a),
      .rd_off_b    (rd_off_b),
      .chain_in_a  (chain_a[g+1]),
      .chain_in_b  (chain_b[g+1]),
      .chain_out_a (chain_a[g]),
      .chain_out_b (chain_b[g])
    );
  end

endmodule

// File: sv/mhps_checker.sv
// Port-level checks for the min-heap priority store, bound to the top level.
module mhps_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input mhps_pkg::status_t status,
  input mhps_pkg::count_t  count,
  input logic              has_min,
  input mhps_pkg::value_t  min_value
);

  import mhps_pkg::*;

  // an empty store reports a zero count and a zero minimum
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_min |-> (count == '0) && (min_value == '0))
    else $error("empty result with nonzero count or minimum");

  // a refused insert can only come from a store that holds entries
  a_full_has_min: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_FULL) |-> has_min)
    else $error("full status on an empty store");

  // one item at a time: the block is busy in the cycle after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while the previous one is still in work");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status) && $stable(count)
      && $stable(has_min) && $stable(min_value))
    else $error("result beat changed while stalled");

endmodule

bind min_heap_priority_store mhps_checker u_mhps_checker (.*);

// File: test/tb_min_heap_priority_store.sv
// Self-checking testbench for the min-heap priority store: predictor, stimulus and result checks.
`timescale 1ns / 1ps

module tb_min_heap_priority_store;
  import mhps_pkg::*;

  localparam int HEAP_DEPTH = 128;
  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 8;
  // settle time sized for the worst delete with a full store
  localparam int SETTLE_CYCLES = 1000;

  // what one result beat should carry
  typedef struct packed {
    status_t status;
    count_t  count;
    logic    has_min;
    value_t  min_value;
  } heap_report_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  logic    action;
  value_t  value;
  logic    result_valid;
  logic    result_ready;
  status_t status;
  count_t  count;
  logic    has_min;
  value_t  min_value;

  // idle percentages of the sender and the receiver, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;

  // predictor state: a plain copy of the heap
  value_t heap_keys [HEAP_DEPTH];
  int     heap_size;

  heap_report_t pending_reports [$];

  min_heap_priority_store #(
    .CAPACITY (HEAP_DEPTH),
    .KEY_WIDTH(32)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .action      (action),
    .value       (value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status      (status),
    .count       (count),
    .has_min     (has_min),
    .min_value   (min_value)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void swap_keys(int a, int b);
    value_t t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // push a node down until neither child is smaller
  function automatic void sink_key(int node);
    int  least;
    int  left;
    int  right;
    bit  moving;
    moving = 1'b1;
    while (moving) begin
      least = node;
      left  = 2 * node + 1;
      right = 2 * node + 2;
      if (left < heap_size && heap_keys[left] < heap_keys[least]) least = left;
      if (right < heap_size && heap_keys[right] < heap_keys[least]) least = right;
      if (least == node) begin
        moving = 1'b0;
      end else begin
        swap_keys(node, least);
        node = least;
      end
    end
  endfunction

  // apply one item beat to the predicted heap and return the report it causes
  function automatic heap_report_t apply_item(logic act, value_t key);
    heap_report_t r;
    int pos;
    int idx;
    r.status = ST_DONE;
    if (act == ACT_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_size;
        heap_keys[pos] = key;
        heap_size++;
        while (pos > 0 && heap_keys[pos] < heap_keys[(pos - 1) / 2]) begin
          swap_keys(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
      end
    end else begin
      // first match in array order, not in heap order
      idx = 0;
      while (idx < heap_size && heap_keys[idx] != key) idx++;
      if (idx >= heap_size) begin
        r.status = ST_NOT_FOUND;
      end else begin
        swap_keys(idx, heap_size - 1);
        heap_size--;
        // full bottom-up rebuild
        for (int n = heap_size / 2; n > 0; n--) sink_key(n - 1);
      end
    end
    r.count     = count_t'(heap_size);
    r.has_min   = (heap_size > 0);
    r.min_value = (heap_size > 0) ? heap_keys[0] : '0;
    return r;
  endfunction

  function automatic bit key_held(value_t key);
    for (int i = 0; i < heap_size; i++) begin
      if (heap_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // mix of a narrow pool (many duplicates), full-range keys and the extremes
  function automatic value_t pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return value_t'($urandom_range(0, 16)) - value_t'(8);
    if (sel < 9) return value_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  // a key that is most likely held, so deletes mostly hit
  function automatic value_t pick_held_key();
    if (heap_size == 0) return pick_key();
    return heap_keys[$urandom_range(0, heap_size - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a clock edge, returns at the edge the beat is taken.
  // Valid stays high on return; the next call either reloads it or drops it.
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic act, input value_t key);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    action     <= act;
    value      <= key;
    do @(posedge clk); while (!item_ready);
    pending_reports.push_back(apply_item(act, key));
  endtask

  // hold off the sender until every expected result beat has come back
  task automatic pause_until_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    heap_report_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          mismatch_count++;
        end
        if (count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, count);
          mismatch_count++;
        end
        if (has_min !== exp_r.has_min) begin
          $error("has_min: expected %0d, got %0d", exp_r.has_min, has_min);
          mismatch_count++;
        end
        if (min_value !== exp_r.min_value) begin
          $error("min_value: expected %0d, got %0d", exp_r.min_value, min_value);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // extremes, duplicates, first-match delete, misses and empty store
  task automatic test_directed();
    send_item(ACT_DELETE, 32'sd0);              // delete on empty
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_INSERT, 32'sh8000_0000);      // new root
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, -32'sd1);
    send_item(ACT_INSERT, 32'sd1);
    send_item(ACT_INSERT, 32'sd5);
    send_item(ACT_INSERT, 32'sd5);
    send_item(ACT_INSERT, 32'sd5);
    send_item(ACT_DELETE, 32'sd5);              // duplicate keys
    send_item(ACT_DELETE, 32'sd77);             // missing key
    send_item(ACT_DELETE, 32'sh8000_0000);      // root removed
    send_item(ACT_DELETE, 32'sh7FFF_FFFF);
    send_item(ACT_DELETE, -32'sd1);
    send_item(ACT_DELETE, 32'sd5);
    send_item(ACT_DELETE, 32'sd5);
    send_item(ACT_DELETE, 32'sd5);              // all copies gone, so this one misses
    send_item(ACT_DELETE, 32'sd0);
    send_item(ACT_DELETE, 32'sd1);              // back to empty
    send_item(ACT_INSERT, -32'sd42);
    send_item(ACT_DELETE, -32'sd42);
    send_item(ACT_DELETE, -32'sd42);
  endtask

  // fill to capacity, bounce off the full limit, then drain to empty
  task automatic test_full_store();
    value_t key;
    while (heap_size < HEAP_DEPTH) send_item(ACT_INSERT, pick_key());
    send_item(ACT_INSERT, pick_key());
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_DELETE, pick_held_key());
    send_item(ACT_INSERT, pick_key());
    send_item(ACT_INSERT, pick_key());
    do key = value_t'($urandom); while (key_held(key));
    send_item(ACT_DELETE, key);
    while (heap_size > 0) send_item(ACT_DELETE, pick_held_key());
    send_item(ACT_DELETE, pick_key());
  endtask

  // random walk that keeps the heap mostly small; deletes mostly hit
  task automatic test_random_traffic(input int n_items);
    int ins_pct;
    for (int i = 0; i < n_items; i++) begin
      ins_pct = (heap_size < 24) ? 55 : 35;
      if ($urandom_range(0, 99) < ins_pct) begin
        send_item(ACT_INSERT, pick_key());
      end else if ($urandom_range(0, 99) < 75) begin
        send_item(ACT_DELETE, pick_held_key());
      end else begin
        send_item(ACT_DELETE, pick_key());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    item_valid     = 1'b0;
    action         = ACT_INSERT;
    value          = '0;
    result_ready   = 1'b0;
    send_idle_pct  = 16;
    recv_idle_pct  = 49;
    mismatch_count = 0;
    heap_size      = 0;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    pause_until_drained();
    test_random_traffic(100);
    pause_until_drained();

    send_idle_pct = 49;
    recv_idle_pct = 16;
    test_full_store();
    pause_until_drained();
    test_random_traffic(100);
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100);
    pause_until_drained();

    // let any stray beat show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
